/* hdl/signed_int_to_decimal_ascii_top_defines.svh */
// Assertion macros used by the checker of this block.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication.
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/sitda_pkg.sv */
package sitda_pkg;

	// Default operand width
	localparam int DATA_WIDTH_DEF = 32;

	// Character codes
	localparam logic [5:0] CH_ZERO  = 6'd48;
	localparam logic [5:0] CH_MINUS = 6'd45;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic drop;
		logic emit_sign;
		logic emit_digit;
	} sitda_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic bits_last;
		logic top_zero;
		logic dig_last;
		logic neg;
	} sitda_sts_t;

endpackage

/* hdl/signed_int_to_decimal_ascii_top.sv */
// Signed integer to decimal ASCII text.
// Input: pulse start with value while busy is low; the value is taken at that
// edge and busy rises in the next cycle. value is two's complement.
// Output: one character per strobe cycle, most significant first: '-' for a
// negative value, then the digits without leading zeros ('0' for zero).
// last_char marks the final character. Characters of one number come on
// consecutive cycles; the receiver cannot stall and must take each one.
// Sequence: DATA_WIDTH shift-and-adjust steps (one bit per cycle through the
// BCD digit register), then the leading zero digits are dropped, then the
// sign is sent if negative, then the digits. Each character is registered,
// so the last one appears in the first cycle in which busy is low. A new
// value may be started in that cycle.
// Reset: arst_n clears the controller and the strobe; no output is pending.
module signed_int_to_decimal_ascii_top
	import sitda_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  strobe,
	output logic [5:0]            char_code,
	output logic                  last_char
);

	// Decimal digits needed for the magnitude, log10(2) taken as 77/256
	localparam int NUM_DIGITS = (DATA_WIDTH * 77) / 256 + 1;

	sitda_cmd_t cmd;
	sitda_sts_t sts;

	sitda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	sitda_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.NUM_DIGITS (NUM_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

/* hdl/sitda_ctrl.sv */
module sitda_ctrl
	import sitda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  sitda_sts_t sts,
	output sitda_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	// Sequence load, conversion, zero skip, sign and digit output
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (sts.bits_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.top_zero && !sts.dig_last) begin
					cmd.drop = 1'b1;
				end else if (sts.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				if (sts.dig_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/sitda_dp.sv */
module sitda_dp
	import sitda_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int NUM_DIGITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [DATA_WIDTH-1:0] value,
	input  sitda_cmd_t            cmd,
	output sitda_sts_t            sts,
	output logic                  strobe,
	output logic [5:0]            char_code,
	output logic                  last_char
);

	localparam int BCD_W = 4 * NUM_DIGITS;
	localparam int BCW   = $clog2(DATA_WIDTH + 1);
	localparam int DCW   = $clog2(NUM_DIGITS + 1);

	logic [DATA_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic                  neg_q;
	logic [BCW-1:0]        bit_cnt_q;
	logic [DCW-1:0]        dig_cnt_q;
	logic [3:0]            top_dig;
	logic                  strobe_q;
	logic [5:0]            char_q;
	logic                  last_q;

	assign top_dig = bcd_q[BCD_W-1 -: 4];

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign sts.bits_last = (bit_cnt_q == BCW'(1));
	assign sts.top_zero  = (top_dig == 4'd0);
	assign sts.dig_last  = (dig_cnt_q == DCW'(1));
	assign sts.neg       = neg_q;

	// Load magnitude, run shift-and-adjust, drop leading digits and step through emitted digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= BCW'(DATA_WIDTH);
			dig_cnt_q <= DCW'(NUM_DIGITS);
		end else if (cmd.shift) begin
			bit_cnt_q <= bit_cnt_q - BCW'(1);
		end else if (cmd.drop || cmd.emit_digit) begin
			dig_cnt_q <= dig_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[DATA_WIDTH-1];
			mag_q <= value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[DATA_WIDTH-1]};
			mag_q <= {mag_q[DATA_WIDTH-2:0], 1'b0};
		end else if (cmd.drop || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'b0000};
		end
	end

	// Hold one character transfer in the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_sign || cmd.emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CH_ZERO + {2'b00, top_dig};
			last_q <= sts.dig_last;
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

/* hdl/sitda_checker.sv */
`include "signed_int_to_decimal_ascii_top_defines.svh"

module sitda_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [5:0] char_code,
	input logic       last_char
);

	// An accepted value makes the block busy
	`SITDA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted value did not raise busy")

	// Characters of one number come without gaps
	`SITDA_ASSERT_NEXT(a_run_gapless, strobe && !last_char, strobe, "gap in a character run")

	// Only the final character may appear once the block is idle
	`SITDA_ASSERT_NOW(a_idle_last, strobe && !busy, last_char, "non-final character while idle")

	// Every character is a minus sign or a digit
	`SITDA_ASSERT_NOW(a_char_range, strobe, (char_code == 6'd45) || ((char_code >= 6'd48) && (char_code <= 6'd57)), "character code out of range")

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.char_code (char_code),
	.last_char (last_char)
);
